// ===== rtl/drt_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// drt_pkg
// Shared types, constants and codes of the damage rectangle tracker.
// ----------------------------------------------------------------------------
package drt_pkg;

    localparam int MAX_RECTS_DEF   = 32;
    localparam int NUM_BUFFERS_DEF = 2;
    localparam int SCREEN_MAX_DEF  = 4096;

    localparam int CFG_W   = 13;
    localparam int COORD_W = 12;
    localparam int DIM_W   = 13;
    localparam int AREA_W  = 32;
    localparam int REQ_W   = 16;

    typedef enum logic
    {
        REG_SCREEN_WIDTH  = 1'b0,
        REG_SCREEN_HEIGHT = 1'b1
    } cfg_reg_t;

    typedef enum logic
    {
        FUNC_REPORT  = 1'b0,
        FUNC_PRESENT = 1'b1
    } func_t;

    typedef struct packed
    {
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [DIM_W-1:0]   w;
        logic [DIM_W-1:0]   h;
    } box_t;

    typedef enum logic [4:0]
    {
        S_IDLE,
        S_CLIP,
        S_AREA,
        S_BUF,
        S_APPEND,
        S_SHR_RD,
        S_SHR_ACC,
        S_SHR_WR,
        S_SHR_SUM,
        S_SHR_DONE,
        S_PRES,
        S_PRD,
        S_PLD,
        S_POUT,
        S_PCLR
    } state_t;

    typedef struct packed
    {
        logic latch_in;
        logic clip;
        logic area;
        logic buf_next;
        logic append;
        logic shr_start;
        logic mem_rd;
        logic shr_acc;
        logic shr_wr;
        logic shr_sum;
        logic shr_done;
        logic pres_whole;
        logic pres_empty;
        logic pres_load;
        logic pres_next;
        logic pres_clr;
    } cmd_t;

    typedef struct packed
    {
        logic func_present;
        logic drop;
        logic buf_last;
        logic cur_whole;
        logic cur_full;
        logic cur_empty;
        logic run_end;
        logic shr_last;
        logic out_last;
    } status_t;

endpackage
`default_nettype wire

// ===== rtl/drt_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// drt_ctrl
// Sequencer: clip, per-buffer append, list halving and present readout.
// ----------------------------------------------------------------------------
module drt_ctrl
(
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            in_valid,
    output logic                 in_ready,
    output logic                 out_valid,
    input  wire logic            out_ready,
    input  wire drt_pkg::status_t sts,
    output drt_pkg::cmd_t        cmd
);
    import drt_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_CLIP;
                end
            end
            S_CLIP:
            begin
                state_next = sts.func_present ? S_PRES : S_AREA;
            end
            S_AREA:
            begin
                state_next = sts.drop ? S_IDLE : S_BUF;
            end
            S_BUF:
            begin
                if (sts.cur_whole)
                begin
                    state_next = sts.buf_last ? S_IDLE : S_BUF;
                end
                else if (sts.cur_full)
                begin
                    state_next = S_SHR_RD;
                end
                else
                begin
                    state_next = S_APPEND;
                end
            end
            S_APPEND:
            begin
                state_next = sts.buf_last ? S_IDLE : S_BUF;
            end
            S_SHR_RD:   state_next = S_SHR_ACC;
            S_SHR_ACC:  state_next = sts.run_end ? S_SHR_WR : S_SHR_RD;
            S_SHR_WR:   state_next = S_SHR_SUM;
            S_SHR_SUM:  state_next = sts.shr_last ? S_SHR_DONE : S_SHR_RD;
            S_SHR_DONE: state_next = S_BUF;
            S_PRES:
            begin
                state_next = (sts.cur_whole || sts.cur_empty) ? S_POUT : S_PRD;
            end
            S_PRD:      state_next = S_PLD;
            S_PLD:      state_next = S_POUT;
            S_POUT:
            begin
                if (out_ready)
                begin
                    state_next = sts.out_last ? S_PCLR : S_PRD;
                end
            end
            S_PCLR:     state_next = S_IDLE;
            default:    state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        cmd       = '0;
        in_ready  = 1'b0;
        out_valid = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready     = 1'b1;
                cmd.latch_in = in_valid;
            end
            S_CLIP:     cmd.clip = 1'b1;
            S_AREA:     cmd.area = 1'b1;
            S_BUF:
            begin
                if (sts.cur_whole)
                begin
                    cmd.buf_next = 1'b1;
                end
                else if (sts.cur_full)
                begin
                    cmd.shr_start = 1'b1;
                end
            end
            S_APPEND:
            begin
                cmd.append   = 1'b1;
                cmd.buf_next = 1'b1;
            end
            S_SHR_RD:   cmd.mem_rd   = 1'b1;
            S_SHR_ACC:  cmd.shr_acc  = 1'b1;
            S_SHR_WR:   cmd.shr_wr   = 1'b1;
            S_SHR_SUM:  cmd.shr_sum  = 1'b1;
            S_SHR_DONE: cmd.shr_done = 1'b1;
            S_PRES:
            begin
                cmd.pres_whole = sts.cur_whole;
                cmd.pres_empty = !sts.cur_whole && sts.cur_empty;
            end
            S_PRD:      cmd.mem_rd    = 1'b1;
            S_PLD:      cmd.pres_load = 1'b1;
            S_POUT:
            begin
                out_valid     = 1'b1;
                cmd.pres_next = out_ready && !sts.out_last;
            end
            S_PCLR:     cmd.pres_clr = 1'b1;
            default:    cmd = '0;
        endcase
    end

endmodule
`default_nettype wire

// ===== rtl/drt_datapath.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// drt_datapath
// Config, clipping, per-buffer lists, rectangle store and result register.
// ----------------------------------------------------------------------------
module drt_datapath
#(
    parameter int MAX_RECTS   = drt_pkg::MAX_RECTS_DEF,
    parameter int NUM_BUFFERS = drt_pkg::NUM_BUFFERS_DEF,
    parameter int SCREEN_MAX  = drt_pkg::SCREEN_MAX_DEF
)
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_we,
    input  wire logic                          cfg_index,
    input  wire logic [drt_pkg::CFG_W-1:0]     cfg_data,
    input  wire logic                          func,
    input  wire logic                          to_screen,
    input  wire logic signed [drt_pkg::REQ_W-1:0] req_x,
    input  wire logic signed [drt_pkg::REQ_W-1:0] req_y,
    input  wire logic [drt_pkg::REQ_W-1:0]     req_w,
    input  wire logic [drt_pkg::REQ_W-1:0]     req_h,
    input  wire drt_pkg::cmd_t                 cmd,
    output drt_pkg::status_t                   sts,
    output logic                               buffer_index,
    output logic [drt_pkg::COORD_W-1:0]        rect_x,
    output logic [drt_pkg::COORD_W-1:0]        rect_y,
    output logic [drt_pkg::DIM_W-1:0]          rect_w,
    output logic [drt_pkg::DIM_W-1:0]          rect_h,
    output logic                               whole_screen,
    output logic                               empty_res,
    output logic                               last
);
    import drt_pkg::*;

    localparam int BUFW      = (NUM_BUFFERS > 1) ? $clog2(NUM_BUFFERS) : 1;
    localparam int IDXW      = $clog2(MAX_RECTS);
    localparam int CNTW      = $clog2(MAX_RECTS + 1);
    localparam int TARGET    = MAX_RECTS / 2;
    localparam int RUN       = (MAX_RECTS + TARGET - 1) / TARGET;
    localparam int RUNW      = $clog2(RUN);
    localparam int MEM_DEPTH = NUM_BUFFERS << IDXW;
    localparam int SW        = REQ_W + 2;

    logic [CFG_W-1:0]  scr_w_reg;
    logic [CFG_W-1:0]  scr_h_reg;
    logic [DIM_W-1:0]  sw_eff;
    logic [DIM_W-1:0]  sh_eff;
    logic [AREA_W-1:0] scr_area_reg;

    logic                    func_reg;
    logic                    to_screen_reg;
    logic signed [REQ_W-1:0] rx_reg;
    logic signed [REQ_W-1:0] ry_reg;
    logic [REQ_W-1:0]        rw_reg;
    logic [REQ_W-1:0]        rh_reg;

    box_t              box_reg;
    logic              drop_reg;
    logic [AREA_W-1:0] box_area_reg;

    logic [CNTW-1:0]   count_reg [NUM_BUFFERS];
    logic [AREA_W-1:0] area_reg  [NUM_BUFFERS];
    logic              whole_reg [NUM_BUFFERS];
    logic [BUFW-1:0]   back_reg;
    logic [BUFW-1:0]   buf_reg;

    logic [IDXW-1:0]   rd_reg;
    logic [IDXW-1:0]   wo_reg;
    logic [RUNW-1:0]   run_reg;
    logic              shr_last_reg;
    box_t              acc_reg;
    logic [AREA_W-1:0] prod_reg;
    logic [AREA_W-1:0] sum_reg;

    box_t mem [MEM_DEPTH];
    box_t rdata_reg;

    logic out_last_reg;

    // effective screen size
    assign sw_eff = (scr_w_reg > CFG_W'(SCREEN_MAX)) ? DIM_W'(SCREEN_MAX) : scr_w_reg;
    assign sh_eff = (scr_h_reg > CFG_W'(SCREEN_MAX)) ? DIM_W'(SCREEN_MAX) : scr_h_reg;

    // clipping
    logic signed [SW-1:0] xs, ys, ws, hs, wsx, hsy, x1, y1, w1, h1, swe, she, rem_w, rem_h;
    logic signed [SW-1:0] w2, h2;
    logic                 drop_c;

    always_comb
    begin
        xs    = {{2{rx_reg[REQ_W-1]}}, rx_reg};
        ys    = {{2{ry_reg[REQ_W-1]}}, ry_reg};
        ws    = {2'b00, rw_reg};
        hs    = {2'b00, rh_reg};
        swe   = SW'(sw_eff);
        she   = SW'(sh_eff);
        wsx   = ws + xs;
        hsy   = hs + ys;
        x1    = (xs < 0) ? '0 : xs;
        y1    = (ys < 0) ? '0 : ys;
        w1    = (xs < 0) ? wsx : ws;
        h1    = (ys < 0) ? hsy : hs;
        rem_w = swe - x1;
        rem_h = she - y1;
        w2    = (w1 > rem_w) ? rem_w : w1;
        h2    = (h1 > rem_h) ? rem_h : h1;
        drop_c = !to_screen_reg || (w1 <= 0) || (h1 <= 0) || (x1 >= swe) || (y1 >= she);
    end

    // bounding box of accumulator and read entry
    box_t             uni;
    logic [DIM_W-1:0] ra, rb, ba, bb, ux, uy, ur, ub;

    always_comb
    begin
        ux = (acc_reg.x < rdata_reg.x) ? DIM_W'(acc_reg.x) : DIM_W'(rdata_reg.x);
        uy = (acc_reg.y < rdata_reg.y) ? DIM_W'(acc_reg.y) : DIM_W'(rdata_reg.y);
        ra = DIM_W'(acc_reg.x) + acc_reg.w;
        rb = DIM_W'(rdata_reg.x) + rdata_reg.w;
        ba = DIM_W'(acc_reg.y) + acc_reg.h;
        bb = DIM_W'(rdata_reg.y) + rdata_reg.h;
        ur = (rb > ra) ? rb : ra;
        ub = (bb > ba) ? bb : ba;
        uni.x = ux[COORD_W-1:0];
        uni.y = uy[COORD_W-1:0];
        uni.w = ur - ux;
        uni.h = ub - uy;
    end

    logic [AREA_W-1:0] area_new;
    assign area_new = area_reg[buf_reg] + box_area_reg;

    always_comb
    begin
        sts.func_present = (func_reg == FUNC_PRESENT);
        sts.drop         = drop_reg;
        sts.buf_last     = (buf_reg == BUFW'(NUM_BUFFERS - 1));
        sts.cur_whole    = whole_reg[buf_reg];
        sts.cur_full     = (count_reg[buf_reg] >= CNTW'(MAX_RECTS));
        sts.cur_empty    = (count_reg[buf_reg] == '0);
        sts.run_end      = (run_reg == RUNW'(RUN - 1)) || (rd_reg == IDXW'(MAX_RECTS - 1));
        sts.shr_last     = shr_last_reg;
        sts.out_last     = out_last_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scr_w_reg <= CFG_W'(640);
            scr_h_reg <= CFG_W'(480);
            back_reg  <= BUFW'(1 % NUM_BUFFERS);
            for (int i = 0; i < NUM_BUFFERS; i++)
            begin
                count_reg[i] <= '0;
                area_reg[i]  <= '0;
                whole_reg[i] <= 1'b1;
            end
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_SCREEN_WIDTH:  scr_w_reg <= cfg_data;
                    REG_SCREEN_HEIGHT: scr_h_reg <= cfg_data;
                    default:           scr_w_reg <= scr_w_reg;
                endcase
            end
            if (cmd.append)
            begin
                if (area_new >= scr_area_reg)
                begin
                    whole_reg[buf_reg] <= 1'b1;
                    count_reg[buf_reg] <= '0;
                    area_reg[buf_reg]  <= '0;
                end
                else
                begin
                    count_reg[buf_reg] <= count_reg[buf_reg] + 1'b1;
                    area_reg[buf_reg]  <= area_new;
                end
            end
            if (cmd.shr_done)
            begin
                count_reg[buf_reg] <= CNTW'(wo_reg);
                area_reg[buf_reg]  <= sum_reg;
            end
            if (cmd.pres_clr)
            begin
                count_reg[buf_reg] <= '0;
                area_reg[buf_reg]  <= '0;
                whole_reg[buf_reg] <= 1'b0;
                back_reg <= (buf_reg == BUFW'(NUM_BUFFERS - 1)) ? '0 : buf_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        scr_area_reg <= AREA_W'(sw_eff * sh_eff);
        if (cmd.latch_in)
        begin
            func_reg      <= func;
            to_screen_reg <= to_screen;
            rx_reg        <= req_x;
            ry_reg        <= req_y;
            rw_reg        <= req_w;
            rh_reg        <= req_h;
            buf_reg       <= back_reg;
            rd_reg        <= '0;
        end
        if (cmd.clip)
        begin
            drop_reg  <= drop_c;
            box_reg.x <= x1[COORD_W-1:0];
            box_reg.y <= y1[COORD_W-1:0];
            box_reg.w <= w2[DIM_W-1:0];
            box_reg.h <= h2[DIM_W-1:0];
        end
        if (cmd.area)
        begin
            box_area_reg <= AREA_W'(box_reg.w * box_reg.h);
            buf_reg      <= '0;
        end
        if (cmd.buf_next)
        begin
            buf_reg <= buf_reg + 1'b1;
        end
        if (cmd.append)
        begin
            mem[{buf_reg, count_reg[buf_reg][IDXW-1:0]}] <= box_reg;
        end
        if (cmd.shr_start)
        begin
            rd_reg  <= '0;
            wo_reg  <= '0;
            run_reg <= '0;
            sum_reg <= '0;
        end
        if (cmd.mem_rd)
        begin
            rdata_reg <= mem[{buf_reg, rd_reg}];
        end
        if (cmd.shr_acc)
        begin
            acc_reg      <= (run_reg == '0) ? rdata_reg : uni;
            rd_reg       <= rd_reg + 1'b1;
            run_reg      <= sts.run_end ? '0 : run_reg + 1'b1;
            shr_last_reg <= (rd_reg == IDXW'(MAX_RECTS - 1));
        end
        if (cmd.shr_wr)
        begin
            mem[{buf_reg, wo_reg}] <= acc_reg;
            prod_reg <= AREA_W'(acc_reg.w * acc_reg.h);
        end
        if (cmd.shr_sum)
        begin
            sum_reg <= sum_reg + prod_reg;
            wo_reg  <= wo_reg + 1'b1;
        end
        if (cmd.pres_whole)
        begin
            rect_x       <= '0;
            rect_y       <= '0;
            rect_w       <= sw_eff;
            rect_h       <= sh_eff;
            whole_screen <= 1'b1;
            empty_res    <= 1'b0;
            out_last_reg <= 1'b1;
        end
        if (cmd.pres_empty)
        begin
            rect_x       <= '0;
            rect_y       <= '0;
            rect_w       <= '0;
            rect_h       <= '0;
            whole_screen <= 1'b0;
            empty_res    <= 1'b1;
            out_last_reg <= 1'b1;
        end
        if (cmd.pres_load)
        begin
            rect_x       <= rdata_reg.x;
            rect_y       <= rdata_reg.y;
            rect_w       <= rdata_reg.w;
            rect_h       <= rdata_reg.h;
            whole_screen <= 1'b0;
            empty_res    <= 1'b0;
            out_last_reg <= ((CNTW'(rd_reg) + 1'b1) == count_reg[buf_reg]);
        end
        if (cmd.pres_next)
        begin
            rd_reg <= rd_reg + 1'b1;
        end
    end

    assign buffer_index = buf_reg[0];
    assign last         = out_last_reg;

endmodule
`default_nettype wire

// ===== rtl/damage_rect_tracker_core.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// damage_rect_tracker_core
// Per-buffer damage list tracker with clipping, halving and present readout.
// ----------------------------------------------------------------------------
//  channel  handshake            payload
//  cfg      cfg_we               cfg_index, cfg_data
//  in       in_valid/in_ready    func, to_screen, req_x, req_y, req_w, req_h
//  out      out_valid/out_ready  buffer_index, rect_x..rect_h, whole_screen,
//                                empty_res, last
//
//  A kept report is clipped and sized, then each buffer in turn is skipped
//  (whole) or appended to; a dropped one ends after sizing. A full list
//  first adds a halving pass that merges runs of entries into bounding boxes.
//  A list present reads, loads and sends each beat; a whole or empty one
//  sends a single beat. Reset idles the sequencer, empties each list and
//  marks it whole; the store needs no clearing pass. out stalls hold the beat and the sequencer.
module damage_rect_tracker_core
#(
    parameter int MAX_RECTS   = drt_pkg::MAX_RECTS_DEF,
    parameter int NUM_BUFFERS = drt_pkg::NUM_BUFFERS_DEF,
    parameter int SCREEN_MAX  = drt_pkg::SCREEN_MAX_DEF
)
(
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             cfg_we,
    input  wire logic                             cfg_index,
    input  wire logic [drt_pkg::CFG_W-1:0]        cfg_data,
    input  wire logic                             in_valid,
    output logic                                  in_ready,
    input  wire logic                             func,
    input  wire logic                             to_screen,
    input  wire logic signed [drt_pkg::REQ_W-1:0] req_x,
    input  wire logic signed [drt_pkg::REQ_W-1:0] req_y,
    input  wire logic [drt_pkg::REQ_W-1:0]        req_w,
    input  wire logic [drt_pkg::REQ_W-1:0]        req_h,
    output logic                                  out_valid,
    input  wire logic                             out_ready,
    output logic                                  buffer_index,
    output logic [drt_pkg::COORD_W-1:0]           rect_x,
    output logic [drt_pkg::COORD_W-1:0]           rect_y,
    output logic [drt_pkg::DIM_W-1:0]             rect_w,
    output logic [drt_pkg::DIM_W-1:0]             rect_h,
    output logic                                  whole_screen,
    output logic                                  empty_res,
    output logic                                  last
);
    import drt_pkg::*;

    cmd_t    cmd;
    status_t sts;

    drt_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    drt_datapath
    #(
        .MAX_RECTS   (MAX_RECTS),
        .NUM_BUFFERS (NUM_BUFFERS),
        .SCREEN_MAX  (SCREEN_MAX)
    )
    u_dp
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .func         (func),
        .to_screen    (to_screen),
        .req_x        (req_x),
        .req_y        (req_y),
        .req_w        (req_w),
        .req_h        (req_h),
        .cmd          (cmd),
        .sts          (sts),
        .buffer_index (buffer_index),
        .rect_x       (rect_x),
        .rect_y       (rect_y),
        .rect_w       (rect_w),
        .rect_h       (rect_h),
        .whole_screen (whole_screen),
        .empty_res    (empty_res),
        .last         (last)
    );

endmodule
`default_nettype wire

// ===== rtl/drt_checker.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// drt_checker
// Port-level checks of the damage rectangle tracker.
// ----------------------------------------------------------------------------
module drt_checker
(
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        in_ready,
    input wire logic        out_valid,
    input wire logic        out_ready,
    input wire logic        whole_screen,
    input wire logic        empty_res,
    input wire logic        last,
    input wire logic [11:0] rect_x,
    input wire logic [12:0] rect_w
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("out beat dropped while stalled");

    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !in_ready)
        else $error("input taken during present readout");

    a_empty: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && empty_res |-> last && !whole_screen && rect_w == '0)
        else $error("bad empty beat");

    a_whole: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && whole_screen |-> last && rect_x == '0)
        else $error("bad whole-screen beat");

endmodule

bind damage_rect_tracker_core drt_checker u_drt_checker
(
    .clk          (clk),
    .rst_n        (rst_n),
    .in_ready     (in_ready),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .whole_screen (whole_screen),
    .empty_res    (empty_res),
    .last         (last),
    .rect_x       (rect_x),
    .rect_w       (rect_w)
);
`default_nettype wire
